// ===== rtl/elfhp_pkg.sv =====
package elfhp_pkg;

    localparam int FIELD_COUNT  = 17;
    localparam int HEADER_BYTES = 52;

    localparam logic [31:0] ELF_MAGIC   = 32'h7F45_4C46;
    localparam logic [31:0] ET_LOPROC   = 32'h0000_FF00;
    localparam logic [31:0] ET_HIPROC   = 32'h0000_FFFF;
    localparam logic [31:0] ET_LAST_STD = 32'h0000_0004;
    localparam logic [31:0] ENC_LSB     = 32'h0000_0001;
    localparam logic [31:0] ENC_MSB     = 32'h0000_0002;

    // Field indexes that carry a check or a special role.
    localparam logic [4:0] FID_MAGIC    = 5'd0;
    localparam logic [4:0] FID_CLASS    = 5'd1;
    localparam logic [4:0] FID_DATA     = 5'd2;
    localparam logic [4:0] FID_IDENTVER = 5'd3;
    localparam logic [4:0] FID_TYPE     = 5'd4;
    localparam logic [4:0] FID_VERSION  = 5'd6;
    localparam logic [4:0] FID_SHSTRNDX = 5'd16;

    // Result status codes.
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_BAD_MAGIC   = 3'd1;
    localparam logic [2:0] ST_BAD_CLASS   = 3'd2;
    localparam logic [2:0] ST_BAD_DATA    = 3'd3;
    localparam logic [2:0] ST_BAD_IDENT   = 3'd4;
    localparam logic [2:0] ST_BAD_TYPE    = 3'd5;
    localparam logic [2:0] ST_BAD_VERSION = 3'd6;

    localparam logic [5:0] FLD_START [FIELD_COUNT] = '{
        6'd0, 6'd4, 6'd5, 6'd6, 6'd16, 6'd18, 6'd20, 6'd24, 6'd28,
        6'd32, 6'd36, 6'd40, 6'd42, 6'd44, 6'd46, 6'd48, 6'd50
    };
    localparam logic [2:0] FLD_LEN [FIELD_COUNT] = '{
        3'd4, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd4, 3'd4, 3'd4,
        3'd4, 3'd4, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2
    };

    typedef struct packed {
        logic [5:0]  pos;
        logic [31:0] acc;
        logic        little_endian;
        logic        halted;
    } parse_state_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] value;
        logic [4:0]  field_id;
        logic        header_done;
    } field_result_t;

    typedef struct packed {
        logic       found;
        logic [4:0] id;
        logic [1:0] off;
        logic       last;
    } field_loc_t;

    // Finds the field that covers a header offset. The fields do not overlap,
    // so each compare stands on its own.
    function automatic field_loc_t field_lookup(input logic [5:0] pos);
        field_loc_t loc;
        logic [6:0] rel;
        loc = '0;
        for (int i = 0; i < FIELD_COUNT; i++) begin
            rel = {1'b0, pos} - {1'b0, FLD_START[i]};
            if (pos >= FLD_START[i] && rel < {4'd0, FLD_LEN[i]}) begin
                loc.found = 1'b1;
                loc.id    = 5'(i);
                loc.off   = rel[1:0];
                loc.last  = (rel + 7'd1) == {4'd0, FLD_LEN[i]};
            end
        end
        return loc;
    endfunction

endpackage

// ===== rtl/elfhp_step.sv =====
// One byte of the header parse: locates the byte's field, merges it into the
// accumulator and checks the field once its last byte is in.
module elfhp_step (
    input  elfhp_pkg::parse_state_t  cur,
    input  logic [7:0]               data_byte,
    input  logic                     header_start,
    output elfhp_pkg::parse_state_t  nxt,
    output logic                     res_valid,
    output elfhp_pkg::field_result_t res
);

    elfhp_pkg::parse_state_t base;
    elfhp_pkg::field_loc_t   loc;
    logic [31:0]             acc_in;
    logic [31:0]             acc_new;
    logic [2:0]              st;
    logic                    done;

    always_comb begin
        base = cur;
        if (header_start) begin
            base.pos           = '0;
            base.acc           = '0;
            base.little_endian = 1'b0;
            base.halted        = 1'b0;
        end
    end

    assign loc    = elfhp_pkg::field_lookup(base.pos);
    assign acc_in = (loc.off == 2'd0) ? 32'd0 : base.acc;

    always_comb begin
        if (base.little_endian && loc.id != elfhp_pkg::FID_MAGIC) begin
            acc_new = acc_in | ({24'd0, data_byte} << {loc.off, 3'b000});
        end else begin
            acc_new = {acc_in[23:0], data_byte};
        end
    end

    always_comb begin
        case (loc.id)
            elfhp_pkg::FID_MAGIC: begin
                st = (acc_new != elfhp_pkg::ELF_MAGIC) ? elfhp_pkg::ST_BAD_MAGIC
                                                       : elfhp_pkg::ST_OK;
            end
            elfhp_pkg::FID_CLASS: begin
                st = (acc_new != elfhp_pkg::ENC_LSB && acc_new != elfhp_pkg::ENC_MSB)
                     ? elfhp_pkg::ST_BAD_CLASS : elfhp_pkg::ST_OK;
            end
            elfhp_pkg::FID_DATA: begin
                st = (acc_new != elfhp_pkg::ENC_LSB && acc_new != elfhp_pkg::ENC_MSB)
                     ? elfhp_pkg::ST_BAD_DATA : elfhp_pkg::ST_OK;
            end
            elfhp_pkg::FID_IDENTVER: begin
                st = (acc_new == 32'd0) ? elfhp_pkg::ST_BAD_IDENT : elfhp_pkg::ST_OK;
            end
            elfhp_pkg::FID_TYPE: begin
                st = (acc_new <= elfhp_pkg::ET_LAST_STD || acc_new == elfhp_pkg::ET_LOPROC
                      || acc_new == elfhp_pkg::ET_HIPROC)
                     ? elfhp_pkg::ST_OK : elfhp_pkg::ST_BAD_TYPE;
            end
            elfhp_pkg::FID_VERSION: begin
                st = (acc_new == 32'd0) ? elfhp_pkg::ST_BAD_VERSION : elfhp_pkg::ST_OK;
            end
            default: begin
                st = elfhp_pkg::ST_OK;
            end
        endcase
    end

    assign done = (st != elfhp_pkg::ST_OK) || (loc.id == elfhp_pkg::FID_SHSTRNDX);

    always_comb begin
        nxt       = base;
        res_valid = 1'b0;
        if (!base.halted) begin
            nxt.pos = base.pos + 6'd1;
            if (!loc.found) begin
                if ({1'b0, base.pos} >= 7'(elfhp_pkg::HEADER_BYTES - 1)) begin
                    nxt.halted = 1'b1;
                end
            end else begin
                nxt.acc = acc_new;
                if (loc.last) begin
                    res_valid = 1'b1;
                    if (loc.id == elfhp_pkg::FID_DATA && st == elfhp_pkg::ST_OK) begin
                        nxt.little_endian = (acc_new == elfhp_pkg::ENC_LSB);
                    end
                    if (done) begin
                        nxt.halted = 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        res.field_id    = loc.id;
        res.value       = acc_new;
        res.status      = st;
        res.header_done = done;
    end

endmodule

// ===== rtl/elf32_header_byte_parser.sv =====
// ELF32 file header parser, one header byte per word on the input stream.
// Set s_tuser high on the first byte of each header; that byte always restarts
// the parse, dropping any header still in progress. Bytes that arrive while no
// header is open are dropped without a result. Each completed field gives one
// result word with its index, its value assembled in the header's own byte
// order (the magic is always taken most significant byte first) and a status;
// the padding bytes give nothing. The first failed check gives a result with
// a nonzero status and m_tlast high, after which the parser waits for the next
// header start; m_tlast is also high on the shstrndx field that ends a good
// header. The block takes one byte per clock cycle when the result side does
// not stall. A result is built from a field's last byte on its way from the
// input register through the field step logic into the result register. The
// parse state update is a loop through the state register around that step
// logic, so it alone sets the rate of one byte per cycle.
module elf32_header_byte_parser (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] header_start

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [4:0] field_id, [36:5] field_value, [39:37] status
    output logic        m_tlast    // header_done
);

    // Input register stage.
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_start_reg;

    // Parse state, held between bytes.
    elfhp_pkg::parse_state_t state_reg;
    elfhp_pkg::parse_state_t state_next;

    // Result register stage.
    logic                     m_valid_reg;
    elfhp_pkg::field_result_t m_res_reg;

    logic                     step_valid;
    elfhp_pkg::field_result_t step_res;
    logic                     out_free;

    // The result register can load whenever it is empty or its word is being
    // taken this cycle, and the input register moves on at the same time.
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || out_free;

    elfhp_step u_step (
        .cur          (state_reg),
        .data_byte    (s1_byte_reg),
        .header_start (s1_start_reg),
        .nxt          (state_next),
        .res_valid    (step_valid),
        .res          (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            s1_byte_reg  <= s_tdata;
            s1_start_reg <= s_tuser[0];
        end
    end

    // The state advances exactly when the buffered byte leaves the input
    // register, so a stalled result never lets a byte be counted twice.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.pos           <= '0;
            state_reg.acc           <= '0;
            state_reg.little_endian <= 1'b0;
            state_reg.halted        <= 1'b1;
        end else if (s1_valid_reg && out_free) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= s1_valid_reg && step_valid;
        end
        if (out_free && s1_valid_reg && step_valid) begin
            m_res_reg <= step_res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_res_reg.status, m_res_reg.value, m_res_reg.field_id};
    assign m_tlast  = m_res_reg.header_done;

endmodule

// ===== rtl/elfhp_checker.sv =====
module elfhp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tlast
);

    logic [4:0] fid;
    logic [2:0] st;

    assign fid = m_tdata[4:0];
    assign st  = m_tdata[39:37];

    // A stalled result word holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed while stalled");

    // Every error result closes the header.
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && st != elfhp_pkg::ST_OK |-> m_tlast)
        else $error("error result without header_done");

    // A good header closes only on its last field.
    a_ok_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast && st == elfhp_pkg::ST_OK |-> fid == elfhp_pkg::FID_SHSTRNDX)
        else $error("header_done on a field other than shstrndx");

    // Each error code belongs to one checked field.
    a_err_field: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && st != elfhp_pkg::ST_OK |->
            (fid == elfhp_pkg::FID_MAGIC && st == elfhp_pkg::ST_BAD_MAGIC) ||
            (fid == elfhp_pkg::FID_CLASS && st == elfhp_pkg::ST_BAD_CLASS) ||
            (fid == elfhp_pkg::FID_DATA && st == elfhp_pkg::ST_BAD_DATA) ||
            (fid == elfhp_pkg::FID_IDENTVER && st == elfhp_pkg::ST_BAD_IDENT) ||
            (fid == elfhp_pkg::FID_TYPE && st == elfhp_pkg::ST_BAD_TYPE) ||
            (fid == elfhp_pkg::FID_VERSION && st == elfhp_pkg::ST_BAD_VERSION))
        else $error("error status on the wrong field");

endmodule

bind elf32_header_byte_parser elfhp_checker u_elfhp_checker (.*);
